// ===== sv/raster_focal_window_sum_macros.svh =====
// assertion macros for the focal window sum block
`ifndef RASTER_FOCAL_WINDOW_SUM_MACROS_SVH
`define RASTER_FOCAL_WINDOW_SUM_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RFWS_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rfws assertion failed");
`define RFWS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rfws assertion failed");
`else
`define RFWS_ASSERT_IMP(label, ante, cons)
`define RFWS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== sv/rfws_pkg.sv =====
`timescale 1ns / 1ps
package rfws_pkg;

   // default sizes
   localparam int DEF_MAX_COLUMNS = 1024;
   localparam int DEF_MAX_RADIUS  = 4;
   localparam int DEF_VALUE_WIDTH = 32;

   // configuration register widths
   localparam int COLUMNS_WIDTH   = 11;
   localparam int ROWS_WIDTH      = 16;
   localparam int RADIUS_WIDTH    = 3;
   localparam int NODATA_WIDTH    = 32;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_INDEX_WIDTH = 2;

   // configuration reset values
   localparam logic [COLUMNS_WIDTH-1:0] COLUMNS_RESET = 11'd1024;
   localparam logic [ROWS_WIDTH-1:0]    ROWS_RESET    = 16'd1024;
   localparam logic [RADIUS_WIDTH-1:0]  RADIUS_RESET  = 3'd1;
   localparam logic [NODATA_WIDTH-1:0]  NODATA_RESET  = 32'hD8F1_C000;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_COLUMNS = 2'd0,
      CSR_ROWS    = 2'd1,
      CSR_RADIUS  = 2'd2,
      CSR_NODATA  = 2'd3
   } csr_index_type;

   // request function codes
   localparam logic FUNC_CELL  = 1'b0;
   localparam logic FUNC_FLUSH = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WAIT,
      ST_EMIT
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic req_ready;
      logic take;
      logic scan_init;
      logic scan_step;
      logic emit;
   } ctrl_type;

   // status from datapath to controller
   typedef struct packed {
      logic has_result;
      logic scan_last;
      logic rsp_free;
   } status_type;

endpackage

// ===== sv/rfws_if.sv =====
`timescale 1ns / 1ps
interface rfws_req_if import rfws_pkg::*; #(
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) ();
   logic                   valid;
   logic                   ready;
   logic                   func;
   logic [VALUE_WIDTH-1:0] cell_value;
   logic                   cell_is_nan;

   modport source (output valid, func, cell_value, cell_is_nan, input ready);
   modport sink (input valid, func, cell_value, cell_is_nan, output ready);
endinterface

interface rfws_rsp_if import rfws_pkg::*; #(
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) ();
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] window_sum;
   logic                   is_no_data;
   logic                   frame_end;

   modport source (output valid, window_sum, is_no_data, frame_end, input ready);
   modport sink (input valid, window_sum, is_no_data, frame_end, output ready);
endinterface

// ===== sv/rfws_ram.sv =====
`timescale 1ns / 1ps
module rfws_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 9216
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== sv/rfws_ctrl.sv =====
`timescale 1ns / 1ps
module rfws_ctrl import rfws_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  status_type sts,
   output ctrl_type   ctrl
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && sts.has_result) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.scan_last) state_in = ST_WAIT;
         end
         ST_WAIT: state_in = ST_EMIT;
         ST_EMIT: begin
            if (sts.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      ctrl = '0;
      case (state_ff)
         ST_IDLE: begin
            ctrl.req_ready = 1'b1;
            ctrl.take      = req_valid;
            ctrl.scan_init = req_valid && sts.has_result;
         end
         ST_SCAN: ctrl.scan_step = 1'b1;
         ST_WAIT: ctrl = '0;
         ST_EMIT: ctrl.emit = sts.rsp_free;
         default: ctrl = '0;
      endcase
   end
endmodule

// ===== sv/rfws_datapath.sv =====
`timescale 1ns / 1ps
module rfws_datapath import rfws_pkg::*; #(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int MAX_RADIUS  = DEF_MAX_RADIUS,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  logic                       func,
   input  logic [VALUE_WIDTH-1:0]     cell_value,
   input  logic                       cell_is_nan,
   input  ctrl_type                   ctrl,
   output status_type                 sts,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic [VALUE_WIDTH-1:0]     window_sum,
   output logic                       is_no_data,
   output logic                       frame_end
);
   localparam int STORE_ROWS  = 2 * MAX_RADIUS + 1;
   localparam int STORE_DEPTH = STORE_ROWS * MAX_COLUMNS;
   localparam int AW   = $clog2(STORE_DEPTH);
   localparam int CIW  = $clog2(MAX_COLUMNS);
   localparam int CW   = $clog2(MAX_COLUMNS + 1);
   localparam int SW   = $clog2(STORE_ROWS);
   localparam int RW   = $clog2(MAX_RADIUS + 1);
   localparam int DW   = $clog2(STORE_ROWS);
   localparam int PW   = $clog2(MAX_RADIUS * (MAX_COLUMNS + 1) + 2);
   localparam int SUMW = VALUE_WIDTH + $clog2(STORE_ROWS * STORE_ROWS);
   localparam int WRW  = ROWS_WIDTH + 2;
   localparam int WCW  = CW + 2;
   localparam logic signed [SUMW-1:0] VMAX =
      {{(SUMW - VALUE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
   localparam logic signed [SUMW-1:0] VMIN =
      {{(SUMW - VALUE_WIDTH + 1){1'b1}}, {(VALUE_WIDTH - 1){1'b0}}};

   // configuration registers
   logic [COLUMNS_WIDTH-1:0] columns_ff;
   logic [ROWS_WIDTH-1:0]    rows_ff;
   logic [RADIUS_WIDTH-1:0]  radius_ff;
   logic [NODATA_WIDTH-1:0]  nodata_ff;

   // frame position
   logic [ROWS_WIDTH-1:0] in_row_ff, out_row_ff;
   logic [CIW-1:0]        in_col_ff, out_col_ff;
   logic [SW-1:0]         in_slot_ff, out_slot_ff;
   logic [PW-1:0]         pending_ff;

   // window scan
   logic [DW-1:0]         dr_ff, dc_ff;
   logic signed [WRW-1:0] win_row_ff;
   logic signed [WCW-1:0] win_col_ff;
   logic [SW-1:0]         scan_slot_ff;
   logic                  rd_valid_ff, rd_inb_ff, rd_center_ff;
   logic signed [SUMW-1:0] acc_ff;
   logic                  flag_ff;

   // result register
   logic                   rsp_valid_ff;
   logic [VALUE_WIDTH-1:0] window_sum_ff;
   logic                   is_no_data_ff, frame_end_ff;

   logic [CW-1:0]          cols_eff;
   logic [ROWS_WIDTH-1:0]  rows_eff;
   logic [RW-1:0]          rad_eff;
   logic [PW-1:0]          lag;
   logic [DW-1:0]          span;
   logic [VALUE_WIDTH-1:0] nd;
   logic                   in_done, write_cell, restart, at_end;
   logic [CW-1:0]          in_col_next, out_col_next;
   logic signed [WCW-1:0]  col_start;
   logic signed [WRW-1:0]  row_start;
   logic [SW:0]            slot_sum;
   logic [SW-1:0]          slot_start;
   logic                   inb, center;
   logic [AW-1:0]          wr_addr, rd_addr;
   logic [VALUE_WIDTH:0]   rd_data;
   logic [VALUE_WIDTH-1:0] rd_val;
   logic signed [SUMW-1:0] rd_ext;
   logic                   flag_final;
   logic signed [SUMW-1:0] sum_sat;

   // effective settings
   always_comb begin
      if (columns_ff == '0) begin
         cols_eff = CW'(1);
      end else if (32'(columns_ff) > MAX_COLUMNS) begin
         cols_eff = CW'(MAX_COLUMNS);
      end else begin
         cols_eff = CW'(columns_ff);
      end
      rows_eff = (rows_ff == '0) ? ROWS_WIDTH'(1) : rows_ff;
      rad_eff  = (32'(radius_ff) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_ff);
      lag      = PW'(rad_eff * cols_eff) + PW'(rad_eff);
      span     = DW'({rad_eff, 1'b0});
      nd       = VALUE_WIDTH'({{VALUE_WIDTH{1'b0}}, nodata_ff});
   end

   assign in_done    = in_row_ff >= rows_eff;
   assign write_cell = ctrl.take && (func == FUNC_CELL) && !in_done;
   assign in_col_next  = CW'(in_col_ff) + CW'(1);
   assign out_col_next = CW'(out_col_ff) + CW'(1);
   assign at_end = (out_row_ff == rows_eff - ROWS_WIDTH'(1)) && (out_col_next >= cols_eff);
   assign restart = csr_we || (ctrl.emit && at_end);

   // status
   assign sts.has_result = in_done ||
      ((func == FUNC_CELL) && ((PW + 1)'(pending_ff) + (PW + 1)'(1) > (PW + 1)'(lag)));
   assign sts.scan_last  = (dr_ff == span) && (dc_ff == span);
   assign sts.rsp_free   = !rsp_valid_ff || rsp_ready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= COLUMNS_RESET;
         rows_ff    <= ROWS_RESET;
         radius_ff  <= RADIUS_RESET;
         nodata_ff  <= NODATA_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_COLUMNS: columns_ff <= csr_wdata[COLUMNS_WIDTH-1:0];
            CSR_ROWS:    rows_ff    <= csr_wdata[ROWS_WIDTH-1:0];
            CSR_RADIUS:  radius_ff  <= csr_wdata[RADIUS_WIDTH-1:0];
            CSR_NODATA:  nodata_ff  <= csr_wdata[NODATA_WIDTH-1:0];
            default:     nodata_ff  <= nodata_ff;
         endcase
      end
   end

   // input and output frame counters
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         in_row_ff   <= '0;
         in_col_ff   <= '0;
         in_slot_ff  <= '0;
         out_row_ff  <= '0;
         out_col_ff  <= '0;
         out_slot_ff <= '0;
         pending_ff  <= '0;
      end else begin
         if (write_cell) begin
            pending_ff <= pending_ff + PW'(1);
            if (in_col_next >= cols_eff) begin
               in_col_ff  <= '0;
               in_row_ff  <= in_row_ff + ROWS_WIDTH'(1);
               in_slot_ff <= (32'(in_slot_ff) == STORE_ROWS - 1) ? '0 : in_slot_ff + SW'(1);
            end else begin
               in_col_ff <= in_col_next[CIW-1:0];
            end
         end
         if (ctrl.emit) begin
            pending_ff <= pending_ff - PW'(1);
            if (out_col_next >= cols_eff) begin
               out_col_ff  <= '0;
               out_row_ff  <= out_row_ff + ROWS_WIDTH'(1);
               out_slot_ff <= (32'(out_slot_ff) == STORE_ROWS - 1) ? '0 : out_slot_ff + SW'(1);
            end else begin
               out_col_ff <= out_col_next[CIW-1:0];
            end
         end
      end
   end

   // window start corner
   always_comb begin
      col_start  = $signed({{(WCW - CIW){1'b0}}, out_col_ff}) -
                   $signed({{(WCW - RW){1'b0}}, rad_eff});
      row_start  = $signed({2'b00, out_row_ff}) - $signed({{(WRW - RW){1'b0}}, rad_eff});
      slot_sum   = {1'b0, out_slot_ff} + (SW + 1)'(STORE_ROWS) - (SW + 1)'(rad_eff);
      slot_start = (32'(slot_sum) >= STORE_ROWS) ? SW'(32'(slot_sum) - STORE_ROWS) : SW'(slot_sum);
   end

   // scan position over the window, one cell a cycle
   always_ff @(posedge clock) begin
      if (ctrl.scan_init) begin
         dr_ff        <= '0;
         dc_ff        <= '0;
         win_row_ff   <= row_start;
         win_col_ff   <= col_start;
         scan_slot_ff <= slot_start;
      end else if (ctrl.scan_step) begin
         if (dc_ff == span) begin
            dc_ff        <= '0;
            dr_ff        <= dr_ff + DW'(1);
            win_col_ff   <= col_start;
            win_row_ff   <= win_row_ff + WRW'(1);
            scan_slot_ff <= (32'(scan_slot_ff) == STORE_ROWS - 1) ? '0
                                                                  : scan_slot_ff + SW'(1);
         end else begin
            dc_ff      <= dc_ff + DW'(1);
            win_col_ff <= win_col_ff + WCW'(1);
         end
      end
   end

   assign inb = (win_row_ff >= 0) && (win_row_ff < $signed({2'b00, rows_eff})) &&
                (win_col_ff >= 0) && (win_col_ff < $signed({2'b00, cols_eff}));
   assign center = (dr_ff == DW'(rad_eff)) && (dc_ff == DW'(rad_eff));

   // line store addressing
   assign wr_addr = AW'(in_slot_ff * MAX_COLUMNS) + AW'(in_col_ff);
   assign rd_addr = inb ? AW'(scan_slot_ff * MAX_COLUMNS) + AW'(win_col_ff[CIW-1:0]) : '0;

   rfws_ram #(
      .WIDTH (VALUE_WIDTH + 1),
      .DEPTH (STORE_DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (write_cell),
      .wr_addr (wr_addr),
      .wr_data ({cell_is_nan, cell_value}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // read pipeline tags
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= ctrl.scan_step;
      end
      rd_inb_ff    <= inb;
      rd_center_ff <= center;
   end

   assign rd_val = rd_data[VALUE_WIDTH-1:0];
   assign rd_ext = $signed({{(SUMW - VALUE_WIDTH){rd_val[VALUE_WIDTH-1]}}, rd_val});

   // accumulate window cells
   always_ff @(posedge clock) begin
      if (ctrl.scan_init) begin
         acc_ff  <= '0;
         flag_ff <= 1'b0;
      end else if (rd_valid_ff) begin
         if (rd_inb_ff && rd_data[VALUE_WIDTH]) begin
            flag_ff <= 1'b1;
         end
         if (rd_center_ff && !rd_data[VALUE_WIDTH] && (rd_val == nd)) begin
            flag_ff <= 1'b1;
         end
         if (rd_inb_ff && !rd_data[VALUE_WIDTH] && (rd_val != nd)) begin
            acc_ff <= acc_ff + rd_ext;
         end
      end
   end

   // final overflow checks
   assign flag_final = flag_ff || (acc_ff >= VMAX);
   assign sum_sat    = (acc_ff < VMIN) ? VMIN : acc_ff;

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (ctrl.emit) begin
         window_sum_ff <= flag_final ? nd : sum_sat[VALUE_WIDTH-1:0];
         is_no_data_ff <= flag_final;
         frame_end_ff  <= at_end;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign window_sum = window_sum_ff;
   assign is_no_data = is_no_data_ff;
   assign frame_end  = frame_end_ff;
endmodule

// ===== sv/raster_focal_window_sum.sv =====
`timescale 1ns / 1ps
`include "raster_focal_window_sum_macros.svh"
// Streaming box-window sum over a raster frame with a no-data value. Cells come in
// row-major order; each result leaves in cell order radius*columns+radius items after
// its cell, and flush items after the frame push out the rest. An item that yields a
// result is accepted, then takes one line store read per window cell over the single
// read port, a wait for the last read to land and a load of the output register once
// that register is free. The line store holds 2*MAX_RADIUS+1 rows of MAX_COLUMNS
// cells and needs no clearing after reset.
module raster_focal_window_sum import rfws_pkg::*; #(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int MAX_RADIUS  = DEF_MAX_RADIUS,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   rfws_req_if.sink                   req_bus,
   rfws_rsp_if.source                 rsp_bus
);
   ctrl_type   ctrl;
   status_type sts;

   // sequencer
   rfws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .sts       (sts),
      .ctrl      (ctrl)
   );

   // counters, line store, accumulator and result register
   rfws_datapath #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_RADIUS  (MAX_RADIUS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .func        (req_bus.func),
      .cell_value  (req_bus.cell_value),
      .cell_is_nan (req_bus.cell_is_nan),
      .ctrl        (ctrl),
      .sts         (sts),
      .rsp_ready   (rsp_bus.ready),
      .rsp_valid   (rsp_bus.valid),
      .window_sum  (rsp_bus.window_sum),
      .is_no_data  (rsp_bus.is_no_data),
      .frame_end   (rsp_bus.frame_end)
   );

   assign req_bus.ready = ctrl.req_ready;

   // no request transfer while a window scan runs
   `RFWS_ASSERT_IMP(a_no_take_in_scan, ctrl.scan_step, !req_bus.ready)
   // scan stops after its last window cell
   `RFWS_ASSERT_NEXT(a_scan_stops, ctrl.scan_step && sts.scan_last, !ctrl.scan_step)
   // result loads only into a free output register
   `RFWS_ASSERT_IMP(a_emit_free, ctrl.emit, sts.rsp_free)
endmodule

// ===== tb/raster_focal_window_sum_tb.sv =====
`timescale 1ns / 1ps
module raster_focal_window_sum_tb;
   import rfws_pkg::*;

   localparam int STORE_ROWS  = 2 * DEF_MAX_RADIUS + 1;
   localparam int STORE_DEPTH = STORE_ROWS * DEF_MAX_COLUMNS;
   localparam int SETTLE      = 120;
   localparam int STALL_LIMIT = 20000;
   localparam int ITEM_TARGET = 700;

   typedef struct {
      logic        func;
      logic [31:0] cell_value;
      logic        cell_is_nan;
   } cell_item_t;

   typedef struct {
      logic [31:0] window_sum;
      logic        is_no_data;
      logic        frame_end;
   } window_result_t;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   rfws_req_if #(.VALUE_WIDTH(DEF_VALUE_WIDTH)) req_bus ();
   rfws_rsp_if #(.VALUE_WIDTH(DEF_VALUE_WIDTH)) rsp_bus ();

   raster_focal_window_sum DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   // mirror of the block state
   logic signed [31:0] line_val [STORE_DEPTH];
   bit                 line_nan [STORE_DEPTH];
   logic [10:0] cfg_columns;
   logic [15:0] cfg_rows;
   logic [2:0]  cfg_radius;
   logic [31:0] cfg_nodata;
   int unsigned in_row, in_col, out_row, out_col;

   cell_item_t     pending_cells[$];
   window_result_t expected_sums[$];

   int pushed_count, taken_count, sums_seen, mismatch_count;
   int no_data_seen, frame_ends_seen, frames_configured;
   int gap_left, burst_left, hold_left, pattern_cnt, pattern_period, pattern_duty;
   int idle_cycles;
   bit long_hold_done;

   function automatic int unsigned store_slot(int unsigned r, int unsigned c);
      return (r % STORE_ROWS) * DEF_MAX_COLUMNS + (c % DEF_MAX_COLUMNS);
   endfunction

   function automatic int unsigned eff_columns();
      if (cfg_columns == 0) return 1;
      return (cfg_columns > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS : cfg_columns;
   endfunction

   function automatic int unsigned eff_rows();
      return (cfg_rows == 0) ? 1 : cfg_rows;
   endfunction

   function automatic int unsigned eff_radius();
      return (cfg_radius > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : cfg_radius;
   endfunction

   // register write restarts the frame, store contents are kept
   function automatic void apply_register(csr_index_type idx, logic [31:0] data);
      case (idx)
         CSR_COLUMNS: cfg_columns = data[10:0];
         CSR_ROWS:    cfg_rows = data[15:0];
         CSR_RADIUS:  cfg_radius = data[2:0];
         CSR_NODATA:  cfg_nodata = data;
         default: ;
      endcase
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
   endfunction

   // one accepted item; returns 1 when it releases a window sum
   function automatic bit predict_window(cell_item_t it, output window_result_t res);
      int unsigned cols, nrows, rad, s, cs;
      longint unsigned total, lag, n_in, cur;
      longint sum, rr, cc;
      bit flag, took, in_done;
      cols = eff_columns();
      nrows = eff_rows();
      rad = eff_radius();
      total = longint'(nrows) * cols;
      lag = longint'(rad) * cols + rad;
      in_done = (in_row >= nrows);
      took = 0;
      res = '{default: '0};
      if (it.func == FUNC_CELL && !in_done) begin
         s = store_slot(in_row, in_col);
         line_val[s] = it.cell_value;
         line_nan[s] = it.cell_is_nan;
         in_col++;
         if (in_col >= cols) begin
            in_col = 0;
            in_row++;
         end
         took = 1;
      end else if (!in_done) begin
         return 0;
      end
      n_in = longint'(in_row) * cols + in_col;
      cur = longint'(out_row) * cols + out_col;
      if (took && n_in <= cur + lag) return 0;
      flag = 0;
      sum = 0;
      cs = store_slot(out_row, out_col);
      if (!line_nan[cs] && line_val[cs] == $signed(cfg_nodata)) flag = 1;
      for (int dr = -int'(rad); dr <= int'(rad) && !flag; dr++) begin
         rr = longint'(out_row) + dr;
         if (rr < 0 || rr >= nrows) continue;
         for (int dc = -int'(rad); dc <= int'(rad); dc++) begin
            cc = longint'(out_col) + dc;
            if (cc < 0 || cc >= cols) continue;
            s = store_slot(int'(rr), int'(cc));
            if (line_nan[s]) begin
               flag = 1;
               break;
            end
            if (line_val[s] != $signed(cfg_nodata)) sum += longint'(line_val[s]);
         end
      end
      if (!flag && sum >= 64'sd2147483647) flag = 1;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      res.window_sum = flag ? cfg_nodata : sum[31:0];
      res.is_no_data = flag;
      res.frame_end = (cur + 1 >= total);
      if (cur + 1 >= total) begin
         in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      end else begin
         out_col++;
         if (out_col >= cols) begin
            out_col = 0;
            out_row++;
         end
      end
      return 1;
   endfunction

   // clock, reset and known input levels
   initial begin
      clock = 0;
      reset = 1;
      csr_we = 0;
      csr_index = CSR_COLUMNS;
      csr_wdata = '0;
      req_bus.valid = 0;
      req_bus.func = FUNC_CELL;
      req_bus.cell_value = '0;
      req_bus.cell_is_nan = 0;
      rsp_bus.ready = 0;
      forever #4 clock = ~clock;
   end

   // sender: bursts of transfers with random gaps
   always @(posedge clock) begin : req_driver
      window_result_t res;
      cell_item_t it;
      logic nv;
      if (reset) begin
         req_bus.valid <= 0;
         gap_left = 0;
         burst_left = 10;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            it.func = req_bus.func;
            it.cell_value = req_bus.cell_value;
            it.cell_is_nan = req_bus.cell_is_nan;
            if (predict_window(it, res)) expected_sums.push_back(res);
            taken_count++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            nv = 0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_cells.size() > 0) begin
               it = pending_cells.pop_front();
               nv = 1;
               req_bus.func <= it.func;
               req_bus.cell_value <= it.cell_value;
               req_bus.cell_is_nan <= it.cell_is_nan;
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  burst_left = ($urandom_range(0, 5) == 0) ? 150 : $urandom_range(1, 30);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
            req_bus.valid <= nv;
         end
      end
   end

   // receiver: own stall pattern, one long hold-off, checking of window sums
   always @(posedge clock) begin : rsp_monitor
      window_result_t want;
      logic nr;
      if (reset) begin
         rsp_bus.ready <= 0;
         pattern_cnt = 0;
         pattern_period = 4;
         pattern_duty = 4;
         hold_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            sums_seen++;
            if (rsp_bus.is_no_data) no_data_seen++;
            if (rsp_bus.frame_end) frame_ends_seen++;
            if (expected_sums.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected window sum %h nodata %b end %b",
                           rsp_bus.window_sum, rsp_bus.is_no_data, rsp_bus.frame_end);
            end else begin
               want = expected_sums.pop_front();
               if (rsp_bus.window_sum !== want.window_sum ||
                   rsp_bus.is_no_data !== want.is_no_data ||
                   rsp_bus.frame_end !== want.frame_end) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("sum #%0d: expected %h/%b/%b got %h/%b/%b", sums_seen,
                              want.window_sum, want.is_no_data, want.frame_end,
                              rsp_bus.window_sum, rsp_bus.is_no_data, rsp_bus.frame_end);
               end
            end
         end
         // long hold-off while the sender keeps offering cells
         if (!long_hold_done && sums_seen > 60 && expected_sums.size() >= 1 &&
             pending_cells.size() > 30) begin
            long_hold_done = 1;
            hold_left = 600;
         end
         pattern_cnt++;
         if (pattern_cnt >= 64) begin
            pattern_cnt = 0;
            pattern_period = $urandom_range(1, 6);
            pattern_duty = ($urandom_range(0, 2) == 0) ? pattern_period :
                           $urandom_range(1, pattern_period);
         end
         if (hold_left > 0) begin
            hold_left--;
            nr = 0;
         end else begin
            nr = ((pattern_cnt % pattern_period) < pattern_duty);
         end
         rsp_bus.ready <= nr;
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || csr_we || (req_bus.valid && req_bus.ready) ||
          (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic add_item(logic f, logic [31:0] v, logic n);
      cell_item_t it;
      it.func = f;
      it.cell_value = v;
      it.cell_is_nan = n;
      pending_cells.push_back(it);
      pushed_count++;
   endtask

   task automatic write_register(csr_index_type idx, logic [31:0] data);
      @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      apply_register(idx, data);
      @(posedge clock);
      csr_we <= 0;
   endtask

   // sender pauses until every expected window sum has come
   task automatic wait_drained();
      do @(negedge clock);
      while (taken_count != pushed_count || expected_sums.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [31:0] random_value();
      case ($urandom_range(0, 11))
         0: return cfg_nodata;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         3, 4: return $urandom;
         5: return 32'h4000_0000 + $urandom_range(0, 1000);
         6: return 32'hC000_0000 - $urandom_range(0, 1000);
         default: return $signed($urandom) >>> $urandom_range(8, 24);
      endcase
   endfunction

   // one frame with random content; partial frames stop before the drain
   task automatic queue_frame(int unsigned cols, int unsigned nrows, int unsigned rad,
                              bit partial);
      int unsigned total, limit, lag;
      total = cols * nrows;
      lag = rad * cols + rad;
      limit = partial ? $urandom_range(1, total) : total;
      for (int unsigned k = 0; k < limit; k++) begin
         if ($urandom_range(0, 24) == 0) add_item(FUNC_FLUSH, $urandom, 1'($urandom));
         add_item(FUNC_CELL, random_value(), $urandom_range(0, 15) == 0);
      end
      if (!partial) begin
         // cells during the drain count as flushes
         for (int unsigned k = 0; k < lag + $urandom_range(0, 2); k++)
            add_item($urandom_range(0, 3) != 0 ? FUNC_FLUSH : FUNC_CELL, $urandom,
                     1'($urandom));
      end
   endtask

   // stimulus and end of run
   initial begin
      int unsigned cols, nrows, rad;
      logic [31:0] col_w, rad_w, nd_w;
      for (int k = 0; k < STORE_DEPTH; k++) begin
         line_val[k] = '0;
         line_nan[k] = 0;
      end
      cfg_columns = COLUMNS_RESET;
      cfg_rows = ROWS_RESET;
      cfg_radius = RADIUS_RESET;
      cfg_nodata = NODATA_RESET;
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      repeat (11) @(posedge clock);
      reset <= 0;

      // directed: 4x3 frame, radius 1, overflow, saturation, no-data, nan, early flush
      write_register(CSR_COLUMNS, 4);
      write_register(CSR_ROWS, 3);
      write_register(CSR_RADIUS, 1);
      write_register(CSR_NODATA, 32'h0001_0000);
      add_item(FUNC_FLUSH, '0, 1'b0);
      for (int k = 0; k < 4; k++) add_item(FUNC_CELL, 32'h7FFF_FFFF, 1'b0);
      add_item(FUNC_CELL, 32'h8000_0000, 1'b0);
      add_item(FUNC_CELL, 32'h8000_0000, 1'b0);
      add_item(FUNC_CELL, 32'h0001_0000, 1'b0);
      add_item(FUNC_CELL, 32'h0002_0000, 1'b0);
      add_item(FUNC_CELL, 32'h0000_0005, 1'b1);
      add_item(FUNC_CELL, 32'h0000_0000, 1'b0);
      add_item(FUNC_CELL, 32'hFFFF_FFFF, 1'b0);
      add_item(FUNC_CELL, 32'h0001_0000, 1'b1);
      add_item(FUNC_FLUSH, '0, 1'b0);
      add_item(FUNC_CELL, 32'hFFFF_FFFF, 1'b1);
      add_item(FUNC_FLUSH, '0, 1'b0);
      add_item(FUNC_CELL, 32'h1234_5678, 1'b0);
      add_item(FUNC_FLUSH, '0, 1'b0);
      wait_drained();

      // directed: columns 0 and rows 0 clamp up, oversize radius, sum equal to no-data
      write_register(CSR_COLUMNS, 0);
      write_register(CSR_ROWS, 0);
      write_register(CSR_RADIUS, 7);
      write_register(CSR_NODATA, 5);
      add_item(FUNC_CELL, 5, 1'b0);
      wait_drained();
      write_register(CSR_ROWS, 2);
      add_item(FUNC_CELL, 2, 1'b0);
      add_item(FUNC_CELL, 3, 1'b0);
      for (int k = 0; k < 3; k++) add_item(FUNC_FLUSH, '0, 1'b0);
      wait_drained();

      // extremes: widest row clamped and left partial, then a very tall frame left partial
      write_register(CSR_COLUMNS, 32'h7FF);
      write_register(CSR_ROWS, 1);
      write_register(CSR_RADIUS, 0);
      write_register(CSR_NODATA, 32'h8000_0000);
      for (int k = 0; k < 60; k++) add_item(FUNC_CELL, random_value(), $urandom_range(0, 9) == 0);
      wait_drained();
      write_register(CSR_ROWS, 16'hFFFF);
      write_register(CSR_COLUMNS, 3);
      write_register(CSR_RADIUS, 0);
      write_register(CSR_NODATA, 32'h7FFF_FFFF);
      for (int k = 0; k < 40; k++) add_item(FUNC_CELL, random_value(), $urandom_range(0, 9) == 0);
      wait_drained();
      frames_configured = 4;

      // random frames of small sizes
      while (pushed_count < ITEM_TARGET) begin
         col_w = $urandom_range(0, 12);
         rad_w = $urandom_range(0, 7);
         nd_w = random_value();
         cols = (col_w == 0) ? 1 : col_w;
         nrows = $urandom_range(1, 8);
         rad = (rad_w > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : rad_w;
         write_register(CSR_COLUMNS, col_w);
         write_register(CSR_ROWS, nrows);
         write_register(CSR_RADIUS, rad_w);
         write_register(CSR_NODATA, nd_w);
         frames_configured++;
         repeat ($urandom_range(1, 3)) queue_frame(cols, nrows, rad, 0);
         if ($urandom_range(0, 4) == 0) queue_frame(cols, nrows, rad, 1);
         wait_drained();
      end

      $display("covered %0d items over %0d settings, %0d window sums checked",
               taken_count, frames_configured, sums_seen);
      $display("%0d no-data sums, %0d frame ends, %0d mismatches",
               no_data_seen, frame_ends_seen, mismatch_count);
      if (mismatch_count == 0 && expected_sums.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/rfws_pkg.sv
sv/rfws_if.sv
sv/rfws_ram.sv
sv/rfws_ctrl.sv
sv/rfws_datapath.sv
sv/raster_focal_window_sum.sv
tb/raster_focal_window_sum_tb.sv
